// ===== rtl/kplrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Key press long/repeat detector package
// Shared types, register indexes, command and mode codes.
// ----------------------------------------------------------------------------
package kplrd_pkg;

   localparam int NUM_KEYS   = 8;
   localparam int KEY_SEL_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_MODES        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LEVEL     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_THRESHOLD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_PERIOD    = 3'd4;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_FETCH  = 1'b1;

   localparam logic [1:0] MODE_SHORT  = 2'd0;
   localparam logic [1:0] MODE_LONG   = 2'd1;
   localparam logic [1:0] MODE_REPEAT = 2'd2;

   localparam logic [7:0] HOLD_SAT   = 8'hfe;
   localparam logic [7:0] HOLD_FIRED = 8'hff;

   localparam logic [15:0] RST_KEY_MODES        = 16'h0000;
   localparam logic        RST_ACTIVE_LEVEL     = 1'b0;
   localparam logic [7:0]  RST_LONG_THRESHOLD   = 8'd100;
   localparam logic [7:0]  RST_REPEAT_THRESHOLD = 8'd50;
   localparam logic [7:0]  RST_REPEAT_PERIOD    = 8'd15;

   typedef struct packed {
      logic [15:0] key_modes;
      logic        active_level;
      logic [7:0]  long_threshold;
      logic [7:0]  repeat_threshold;
      logic [7:0]  repeat_period;
   } cfg_type;

   typedef struct packed {
      logic       cmd;
      logic [2:0] key_index;
      logic       raw_level;
   } req_type;

   typedef struct packed {
      logic       event_valid;
      logic [2:0] event_key;
      logic       event_long;
   } rsp_type;

endpackage

// ===== rtl/kplrd_csr.sv =====
// ----------------------------------------------------------------------------
// Key press long/repeat detector configuration registers
// Write-only register file for key modes, active level, hold thresholds and repeat period.
// ----------------------------------------------------------------------------
module kplrd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [kplrd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kplrd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output kplrd_pkg::cfg_type                   cfg
);

   kplrd_pkg::cfg_type cfg_ff;
   kplrd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            kplrd_pkg::CSR_KEY_MODES:        cfg_in.key_modes        = csr_wdata;
            kplrd_pkg::CSR_ACTIVE_LEVEL:     cfg_in.active_level     = csr_wdata[0];
            kplrd_pkg::CSR_LONG_THRESHOLD:   cfg_in.long_threshold   = csr_wdata[7:0];
            kplrd_pkg::CSR_REPEAT_THRESHOLD: cfg_in.repeat_threshold = csr_wdata[7:0];
            kplrd_pkg::CSR_REPEAT_PERIOD:    cfg_in.repeat_period    = csr_wdata[7:0];
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_modes        <= kplrd_pkg::RST_KEY_MODES;
         cfg_ff.active_level     <= kplrd_pkg::RST_ACTIVE_LEVEL;
         cfg_ff.long_threshold   <= kplrd_pkg::RST_LONG_THRESHOLD;
         cfg_ff.repeat_threshold <= kplrd_pkg::RST_REPEAT_THRESHOLD;
         cfg_ff.repeat_period    <= kplrd_pkg::RST_REPEAT_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/kplrd_key_bank.sv =====
// ----------------------------------------------------------------------------
// Key press long/repeat detector key bank
// Per-key level and hold counters with the one-entry event latch.
// ----------------------------------------------------------------------------
module kplrd_key_bank (
   input  logic                clock,
   input  logic                reset,
   input  kplrd_pkg::cfg_type  cfg,
   input  logic                step_en,
   input  kplrd_pkg::req_type  item,
   output kplrd_pkg::rsp_type  result
);

   logic [kplrd_pkg::NUM_KEYS-1:0] last_level_ff;
   logic [kplrd_pkg::NUM_KEYS-1:0] last_level_in;
   logic [7:0] hold_count_ff [kplrd_pkg::NUM_KEYS];
   logic [7:0] hold_count_in [kplrd_pkg::NUM_KEYS];
   logic       latch_valid_ff, latch_valid_in;
   logic [2:0] latch_key_ff, latch_key_in;
   logic       latch_long_ff, latch_long_in;

   logic [kplrd_pkg::KEY_SEL_W-1:0] sel;
   logic       key_ok;
   logic       now, was_pressed;
   logic [1:0] mode;
   logic [7:0] cnt_rd, cnt_mid, cnt_new;
   logic       ev_mid, ev, ev_long;

   assign sel         = item.key_index[kplrd_pkg::KEY_SEL_W-1:0];
   assign key_ok      = (32'(item.key_index) < kplrd_pkg::NUM_KEYS);
   assign now         = (item.raw_level == cfg.active_level);
   assign was_pressed = last_level_ff[sel];
   assign mode        = cfg.key_modes[2*sel +: 2];
   assign cnt_rd      = hold_count_ff[sel];

   always_comb begin
      cnt_mid = cnt_rd;
      ev_mid  = 1'b0;
      if (now && !was_pressed) begin
         ev_mid  = (mode != kplrd_pkg::MODE_LONG);
         cnt_mid = 8'd0;
      end else if (now && was_pressed) begin
         if (cnt_rd < kplrd_pkg::HOLD_SAT) begin
            cnt_mid = cnt_rd + 8'd1;
         end
      end else if (!now && was_pressed) begin
         ev_mid = (mode == kplrd_pkg::MODE_LONG) && (cnt_rd != kplrd_pkg::HOLD_FIRED);
      end

      cnt_new = cnt_mid;
      ev      = ev_mid;
      ev_long = 1'b0;
      case (mode)
         kplrd_pkg::MODE_LONG: begin
            if (cnt_mid == cfg.long_threshold) begin
               ev      = 1'b1;
               ev_long = 1'b1;
               cnt_new = kplrd_pkg::HOLD_FIRED;
            end
         end
         kplrd_pkg::MODE_REPEAT: begin
            if (cnt_mid == cfg.repeat_threshold) begin
               ev      = 1'b1;
               cnt_new = cfg.repeat_threshold - cfg.repeat_period;
            end
         end
         default: begin
            cnt_new = cnt_mid;
         end
      endcase
   end

   always_comb begin
      last_level_in  = last_level_ff;
      hold_count_in  = hold_count_ff;
      latch_valid_in = latch_valid_ff;
      latch_key_in   = latch_key_ff;
      latch_long_in  = latch_long_ff;
      result.event_valid = latch_valid_ff;
      result.event_key   = latch_key_ff;
      result.event_long  = latch_long_ff;
      if (step_en) begin
         if (item.cmd == kplrd_pkg::CMD_FETCH) begin
            latch_valid_in = 1'b0;
            latch_key_in   = 3'd0;
            latch_long_in  = 1'b0;
         end else if (key_ok) begin
            last_level_in[sel] = now;
            hold_count_in[sel] = cnt_new;
            if (ev && !latch_valid_ff) begin
               latch_valid_in = 1'b1;
               latch_key_in   = item.key_index;
               latch_long_in  = ev_long;
            end
            result.event_valid = latch_valid_in;
            result.event_key   = latch_key_in;
            result.event_long  = latch_long_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff  <= '0;
         for (int i = 0; i < kplrd_pkg::NUM_KEYS; i++) begin
            hold_count_ff[i] <= 8'd0;
         end
         latch_valid_ff <= 1'b0;
         latch_key_ff   <= 3'd0;
         latch_long_ff  <= 1'b0;
      end else begin
         last_level_ff  <= last_level_in;
         hold_count_ff  <= hold_count_in;
         latch_valid_ff <= latch_valid_in;
         latch_key_ff   <= latch_key_in;
         latch_long_ff  <= latch_long_in;
      end
   end

   a_empty_latch_zero: assert property (@(posedge clock) disable iff (reset)
      !latch_valid_ff |-> (latch_key_ff == 3'd0) && !latch_long_ff)
      else $error("empty latch holds stale event data");

   a_fetch_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && (item.cmd == kplrd_pkg::CMD_FETCH) |=> !latch_valid_ff)
      else $error("fetch did not clear the latch");

   a_full_latch_holds: assert property (@(posedge clock) disable iff (reset)
      latch_valid_ff && !(step_en && (item.cmd == kplrd_pkg::CMD_FETCH))
      |=> latch_valid_ff && $stable(latch_key_ff) && $stable(latch_long_ff))
      else $error("latched event overwritten before fetch");

endmodule

// ===== rtl/key_press_long_repeat_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Key press long/repeat detector
// Short, long and auto-repeat key event detection with a one-entry latch.
// ----------------------------------------------------------------------------
// One transfer is accepted per cycle, sustained, unless the input stalls.
// A transfer lands in the input register; once the result register can
// take it, it updates the per-key level, hold counter and event latch and
// its result is captured in the result register. All per-key state sits in
// flip-flops and is read, modified and written back as each transfer
// advances, so back-to-back samples of the same key need no forwarding.
// The input stalls only while both registers are full and rsp_stall is high.
module key_press_long_repeat_detector_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  kplrd_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output kplrd_pkg::rsp_type                rsp_data,
   input  logic                              csr_wr_en,
   input  logic [kplrd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kplrd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   kplrd_pkg::cfg_type cfg;
   kplrd_pkg::req_type in_data_ff, in_data_in;
   logic               in_valid_ff, in_valid_in;
   kplrd_pkg::rsp_type out_data_ff, out_data_in;
   logic               out_valid_ff, out_valid_in;
   kplrd_pkg::rsp_type step_result;
   logic               out_ready, advance, req_take;

   kplrd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kplrd_key_bank u_key_bank (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .item    (in_data_ff),
      .result  (step_result)
   );

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = step_result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without a full pipeline");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed transfer lost before the result register");

   a_held_item_stays: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("pending transfer changed while waiting");

endmodule
